### rtl/hll_pkg.sv
`default_nettype none

package hll_pkg;

  // Longest token length that is counted; the count sticks at LEN_CAP.
  localparam int MAX_TOKEN_LENGTH = 4095;
  localparam int LEN_W = 12;
  localparam logic [LEN_W-1:0] LEN_CAP =
    LEN_W'((MAX_TOKEN_LENGTH < 4095) ? MAX_TOKEN_LENGTH : 4095);

  // Lexer modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_NUM   = 3'd1;
  localparam logic [2:0] MODE_QUOTE = 3'd2;
  localparam logic [2:0] MODE_TICK1 = 3'd3;
  localparam logic [2:0] MODE_TICK2 = 3'd4;

  // Prefix classes
  localparam logic [1:0] PC_DIGITS = 2'd0;
  localparam logic [1:0] PC_QUAL   = 2'd1;
  localparam logic [1:0] PC_VALID  = 2'd2;
  localparam logic [1:0] PC_BAD    = 2'd3;

  // Status codes
  localparam logic [2:0] ST_PENDING = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_NOLIT   = 3'd2;
  localparam logic [2:0] ST_UNTERM  = 3'd3;
  localparam logic [2:0] ST_IDLE    = 3'd4;

  // Token kinds
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_NUM  = 3'd1;
  localparam logic [2:0] KIND_BITS = 3'd2;
  localparam logic [2:0] KIND_CHAR = 3'd3;
  localparam logic [2:0] KIND_TICK = 3'd4;

  // Characters
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_D      = 8'h64;

  typedef struct packed {
    logic [2:0]       mode;
    logic [1:0]       pclass;
    logic             prev_e;
    logic [LEN_W-1:0] count;
  } lex_state_t;

  typedef struct packed {
    logic [7:0]       out_char;
    logic [2:0]       status;
    logic [2:0]       token_kind;
    logic [LEN_W-1:0] token_length;
  } lex_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       end_of_source;
  } lex_item_t;

  localparam lex_state_t STATE_RESET = '{mode: MODE_IDLE, pclass: PC_DIGITS,
                                         prev_e: 1'b0, count: '0};

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return is_upper(c) ? (c + 8'd32) : c;
  endfunction

  function automatic logic is_base(input logic [7:0] c);
    return (c == CH_B) || (c == CH_O) || (c == CH_X) || (c == CH_D);
  endfunction

endpackage

`default_nettype wire

### rtl/hll_step.sv
`default_nettype none

// Per-character decision: next lexer state and the result word.
module hll_step import hll_pkg::*; (
  input  wire lex_state_t  cur,
  input  wire lex_item_t   item,
  output lex_state_t       nxt,
  output lex_result_t      res
);

  logic [7:0]       lc;
  logic             eos;
  logic             cont;
  logic [LEN_W-1:0] count_inc;
  logic [1:0]       pclass_next;

  assign eos = item.end_of_source;
  assign lc  = to_lower(item.ch);
  assign count_inc = (cur.count < LEN_CAP) ? (cur.count + LEN_W'(1)) : cur.count;
  assign cont = !eos && (is_alnum(item.ch) || (item.ch == CH_UNDER) ||
                (item.ch == CH_DOT) || (item.ch == CH_HASH) ||
                (((item.ch == CH_PLUS) || (item.ch == CH_MINUS)) && cur.prev_e));

  always_comb begin
    case (cur.pclass)
      PC_DIGITS: begin
        if (is_digit(lc)) pclass_next = PC_DIGITS;
        else if ((lc == CH_U) || (lc == CH_S)) pclass_next = PC_QUAL;
        else if (is_base(lc)) pclass_next = PC_VALID;
        else pclass_next = PC_BAD;
      end
      PC_QUAL: pclass_next = is_base(lc) ? PC_VALID : PC_BAD;
      default: pclass_next = PC_BAD;
    endcase
  end

  always_comb begin
    nxt = cur;
    res.out_char     = eos ? 8'h00 : item.ch;
    res.status       = ST_PENDING;
    res.token_kind   = KIND_NONE;
    res.token_length = '0;
    if (item.first) begin
      nxt = STATE_RESET;
      if (eos) begin
        res.status = ST_NOLIT;
      end else if (is_digit(item.ch)) begin
        nxt.mode  = MODE_NUM;
        nxt.count = LEN_W'(1);
      end else if (item.ch == CH_DQUOTE) begin
        nxt.mode  = MODE_QUOTE;
        nxt.count = LEN_W'(1);
      end else if (item.ch == CH_APOS) begin
        nxt.mode  = MODE_TICK1;
        nxt.count = LEN_W'(1);
      end else begin
        res.status = ST_NOLIT;
      end
    end else begin
      case (cur.mode)
        MODE_NUM: begin
          if (cont) begin
            nxt.count    = count_inc;
            nxt.pclass   = pclass_next;
            nxt.prev_e   = (item.ch == CH_LE) || (item.ch == CH_UE);
            res.out_char = lc;
          end else if (!eos && (item.ch == CH_DQUOTE) && (cur.pclass == PC_VALID)) begin
            nxt.count = count_inc;
            nxt.mode  = MODE_QUOTE;
          end else begin
            res.status       = ST_DONE;
            res.token_kind   = KIND_NUM;
            res.token_length = cur.count;
            nxt              = STATE_RESET;
          end
        end
        MODE_QUOTE: begin
          if (eos || (item.ch == CH_NL)) begin
            res.status       = ST_UNTERM;
            res.token_kind   = KIND_BITS;
            res.token_length = cur.count;
            nxt              = STATE_RESET;
          end else if (item.ch == CH_DQUOTE) begin
            res.status       = ST_DONE;
            res.token_kind   = KIND_BITS;
            res.token_length = count_inc;
            nxt              = STATE_RESET;
          end else begin
            nxt.count = count_inc;
          end
        end
        MODE_TICK1: begin
          if (eos) begin
            res.status       = ST_DONE;
            res.token_kind   = KIND_TICK;
            res.token_length = LEN_W'(1);
            nxt              = STATE_RESET;
          end else begin
            nxt.count = LEN_W'(2);
            nxt.mode  = MODE_TICK2;
          end
        end
        MODE_TICK2: begin
          res.status = ST_DONE;
          if (!eos && (item.ch == CH_APOS)) begin
            res.token_kind   = KIND_CHAR;
            res.token_length = LEN_W'(3);
          end else begin
            res.token_kind   = KIND_TICK;
            res.token_length = LEN_W'(1);
          end
          nxt = STATE_RESET;
        end
        default: begin
          // idle and unused mode codes
          res.status = ST_IDLE;
          nxt        = STATE_RESET;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/hdl_literal_lexer_core.sv
`default_nettype none

// Channel   Handshake             Word
// input     in_valid / in_stall   ch, first, end_of_source
// output    out_valid / out_stall out_char, status, token_kind, token_length
//
// One character per cycle sustained while the output is not stalled; each word
// passes through the input register, then the result register.
// The lexer state moves on when a word passes from the input register to the
// result register, so the next character sees the updated state.
// Synchronous active-high rst empties both registers and returns the lexer
// to idle.
// A stalled output holds the result register; the input register still takes
// a word while the result register is busy and only stalls when both are full.
module hdl_literal_lexer_core import hll_pkg::*; (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire [7:0]        ch,
  input  wire              first,
  input  wire              end_of_source,
  output logic             out_valid,
  input  wire              out_stall,
  output logic [7:0]       out_char,
  output logic [2:0]       status,
  output logic [2:0]       token_kind,
  output logic [LEN_W-1:0] token_length
);

  // input register
  logic        in_full;
  lex_item_t   in_word;
  // lexer state
  lex_state_t  lex_state;
  lex_state_t  lex_state_next;
  // result register
  lex_result_t res_word;
  lex_result_t res_next;

  logic        advance;
  logic        res_free;

  assign res_free = !out_valid || !out_stall;
  assign advance  = in_full && res_free;
  // Input register can load when it is empty or draining this cycle.
  assign in_stall = in_full && !res_free;

  hll_step u_step (
    .cur  (lex_state),
    .item (in_word),
    .nxt  (lex_state_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word <= '{ch: ch, first: first, end_of_source: end_of_source};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state <= STATE_RESET;
    end else if (advance) begin
      lex_state <= lex_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_word <= res_next;
    end
  end

  assign out_char     = res_word.out_char;
  assign status       = res_word.status;
  assign token_kind   = res_word.token_kind;
  assign token_length = res_word.token_length;

  // Character literal always spans three characters.
  a_char_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_DONE) && (token_kind == KIND_CHAR))
      |-> (token_length == LEN_W'(3)))
    else $error("character literal length not three");

  // No kind and no length unless a token finished or ran off.
  a_no_token: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((status == ST_PENDING) || (status == ST_IDLE) ||
                   (status == ST_NOLIT)))
      |-> ((token_kind == KIND_NONE) && (token_length == '0)))
    else $error("kind or length set without a token");

  // Count never passes the cap.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    lex_state.count <= LEN_CAP)
    else $error("character count above cap");

  // Idle lexer carries no count or prefix history.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (lex_state.mode == MODE_IDLE)
      |-> ((lex_state.count == '0) && (lex_state.pclass == PC_DIGITS) &&
           !lex_state.prev_e))
    else $error("idle lexer holds stale state");

  // The input stalls only when the input register is full and the result word is stalled.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hll_pkg::*;

  // Stimulus sizing
  localparam int RANDOM_WORDS = 1390;  // stop the random part near this count
  localparam int HOLD_AT      = 300;   // receiver holds off once this many words are in
  localparam int HOLD_CYCLES  = 120;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       ch = 8'h00;
  logic             first = 1'b0;
  logic             end_of_source = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_char;
  logic [2:0]       status;
  logic [2:0]       token_kind;
  logic [LEN_W-1:0] token_length;

  hdl_literal_lexer_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .ch(ch),
    .first(first),
    .end_of_source(end_of_source),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .status(status),
    .token_kind(token_kind),
    .token_length(token_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #(4_000_000);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Lexer predictor: own copy of the scanner state, advanced once per
  // accepted word, giving the result word that the block must return.
  // ---------------------------------------------------------------------
  logic [2:0]       lx_mode;
  logic [1:0]       lx_class;   // how far the numeric text looks like a size prefix
  logic             lx_prev_e;  // last numeric char was e/E, so a sign may follow
  logic [LEN_W-1:0] lx_count;

  lex_result_t predicted_words[$];
  lex_result_t want;
  int          mismatches = 0;
  int          words_sent = 0;

  function automatic logic num_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic num_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic base_letter(input logic [7:0] c);
    return c == CH_B || c == CH_O || c == CH_X || c == CH_D;
  endfunction

  function automatic void lex_clear();
    lx_mode   = MODE_IDLE;
    lx_class  = PC_DIGITS;
    lx_prev_e = 1'b0;
    lx_count  = '0;
  endfunction

  // Count sticks at the cap; scanning carries on regardless
  function automatic void bump_len();
    if (lx_count < LEN_CAP) lx_count = lx_count + 1'b1;
  endfunction

  function automatic lex_result_t predict_lexeme(input lex_item_t w);
    lex_result_t r;
    logic [7:0]  lc;
    logic        cont;
    r.out_char     = w.end_of_source ? 8'h00 : w.ch;
    r.status       = ST_PENDING;
    r.token_kind   = KIND_NONE;
    r.token_length = '0;
    lc = fold_case(w.ch);
    if (w.first) begin
      // a fresh attempt throws away whatever token was in flight
      lex_clear();
      if (w.end_of_source) begin
        r.status = ST_NOLIT;
      end else if (num_digit(w.ch)) begin
        lx_mode  = MODE_NUM;
        lx_count = LEN_W'(1);
      end else if (w.ch == CH_DQUOTE) begin
        lx_mode  = MODE_QUOTE;
        lx_count = LEN_W'(1);
      end else if (w.ch == CH_APOS) begin
        lx_mode  = MODE_TICK1;
        lx_count = LEN_W'(1);
      end else begin
        r.status = ST_NOLIT;
      end
    end else begin
      case (lx_mode)
        MODE_NUM: begin
          cont = !w.end_of_source &&
                 (num_digit(w.ch) || num_letter(w.ch) || w.ch == CH_UNDER ||
                  w.ch == CH_DOT || w.ch == CH_HASH ||
                  ((w.ch == CH_PLUS || w.ch == CH_MINUS) && lx_prev_e));
          if (cont) begin
            bump_len();
            case (lx_class)
              PC_DIGITS: lx_class = num_digit(lc) ? PC_DIGITS :
                                    (lc == CH_U || lc == CH_S) ? PC_QUAL :
                                    base_letter(lc) ? PC_VALID : PC_BAD;
              PC_QUAL:   lx_class = base_letter(lc) ? PC_VALID : PC_BAD;
              default:   lx_class = PC_BAD;
            endcase
            lx_prev_e  = (lc == CH_LE);
            r.out_char = lc;
          end else if (!w.end_of_source && w.ch == CH_DQUOTE && lx_class == PC_VALID) begin
            // size prefix complete: the quote opens a sized bit string
            bump_len();
            lx_mode = MODE_QUOTE;
          end else begin
            // terminator is lookahead, echoed as it came
            r.status       = ST_DONE;
            r.token_kind   = KIND_NUM;
            r.token_length = lx_count;
            lex_clear();
          end
        end
        MODE_QUOTE: begin
          if (w.end_of_source || w.ch == CH_NL) begin
            r.status       = ST_UNTERM;
            r.token_kind   = KIND_BITS;
            r.token_length = lx_count;
            lex_clear();
          end else begin
            bump_len();
            if (w.ch == CH_DQUOTE) begin
              r.status       = ST_DONE;
              r.token_kind   = KIND_BITS;
              r.token_length = lx_count;
              lex_clear();
            end
          end
        end
        MODE_TICK1: begin
          if (w.end_of_source) begin
            r.status       = ST_DONE;
            r.token_kind   = KIND_TICK;
            r.token_length = LEN_W'(1);
            lex_clear();
          end else begin
            lx_count = LEN_W'(2);
            lx_mode  = MODE_TICK2;
          end
        end
        MODE_TICK2: begin
          r.status = ST_DONE;
          if (!w.end_of_source && w.ch == CH_APOS) begin
            r.token_kind   = KIND_CHAR;
            r.token_length = LEN_W'(3);
          end else begin
            r.token_kind   = KIND_TICK;
            r.token_length = LEN_W'(1);
          end
          lex_clear();
        end
        default: begin
          // idle, and the unused mode codes with it
          r.status = ST_IDLE;
          lex_clear();
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Idling: mostly no gap, often a short one, now and then a long one
  // ---------------------------------------------------------------------
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  int steady_left = 0;  // words still to go with no gap

  task automatic send_word(input logic [7:0] c, input logic f, input logic e,
                           input logic typed = 1'b0, input lex_result_t fixed = '0);
    lex_item_t   w;
    lex_result_t got;
    int          gap;
    if (steady_left > 0) begin
      steady_left--;
      gap = 0;
    end else begin
      gap = gap_cycles();
      if ($urandom_range(0, 29) == 0) steady_left = $urandom_range(30, 120);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    ch            <= c;
    first         <= f;
    end_of_source <= e;
    do @(posedge clk); while (in_stall);
    w = '{ch: c, first: f, end_of_source: e};
    got = predict_lexeme(w);
    // typed rows still advance the predictor, but their own result is expected
    predicted_words.push_back(typed ? fixed : got);
    words_sent++;
  endtask

  // Sender goes quiet until every predicted word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (predicted_words.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Random content helpers
  // ---------------------------------------------------------------------
  localparam logic [7:0] BASE_CHARS [4] = '{CH_B, CH_O, CH_X, CH_D};

  function automatic logic [7:0] mix_case(input logic [7:0] c);
    return $urandom_range(0, 1) ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] any_letter();
    return mix_case(8'h61 + 8'($urandom_range(0, 25)));
  endfunction

  // anything that keeps a bit string open
  function automatic logic [7:0] quoted_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_DQUOTE || c == CH_NL);
    return c;
  endfunction

  function automatic int short_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
  endfunction

  task automatic numeric_body(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_word(any_digit(), 1'b0, 1'b0);
        3, 4:    send_word(any_letter(), 1'b0, 1'b0);
        5:       send_word(CH_UNDER, 1'b0, 1'b0);
        6:       send_word(CH_DOT, 1'b0, 1'b0);
        7:       send_word(CH_HASH, 1'b0, 1'b0);
        default: begin
          // exponent with sign
          send_word($urandom_range(0, 1) ? CH_LE : CH_UE, 1'b0, 1'b0);
          send_word($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0, 1'b0);
        end
      endcase
    end
  endtask

  task automatic numeric_end();
    case ($urandom_range(0, 7))
      0: ;  // cut off by the next token's first word
      1: send_word(8'($urandom), 1'b0, 1'b1);
      2: send_word($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0, 1'b0);
      3: send_word(8'($urandom), 1'b0, 1'b0);
      4: send_word(CH_DQUOTE, 1'b0, 1'b0);
      default: send_word($urandom_range(0, 1) ? 8'h20 : 8'h3B, 1'b0, 1'b0);
    endcase
  endtask

  task automatic quoted_body();
    repeat (short_len()) send_word(quoted_byte(), 1'b0, 1'b0);
    case ($urandom_range(0, 8))
      6: send_word(CH_NL, 1'b0, 1'b0);
      7: send_word(8'($urandom), 1'b0, 1'b1);
      8: ;  // abandoned by a new first word
      default: send_word(CH_DQUOTE, 1'b0, 1'b0);
    endcase
  endtask

  task automatic gen_numeric();
    send_word(any_digit(), 1'b1, 1'b0);
    numeric_body(short_len());
    numeric_end();
  endtask

  // digits [u|s] base "..." -- sometimes spoilt before the quote
  task automatic gen_sized_bits();
    send_word(any_digit(), 1'b1, 1'b0);
    repeat ($urandom_range(0, 2)) send_word(any_digit(), 1'b0, 1'b0);
    if ($urandom_range(0, 1)) send_word(mix_case($urandom_range(0, 1) ? CH_U : CH_S), 1'b0, 1'b0);
    send_word(mix_case(BASE_CHARS[$urandom_range(0, 3)]), 1'b0, 1'b0);
    if ($urandom_range(0, 5) == 0) numeric_body(2);
    send_word(CH_DQUOTE, 1'b0, 1'b0);
    quoted_body();
  endtask

  task automatic gen_plain_bits();
    send_word(CH_DQUOTE, 1'b1, 1'b0);
    quoted_body();
  endtask

  task automatic gen_tick();
    send_word(CH_APOS, 1'b1, 1'b0);
    case ($urandom_range(0, 8))
      0: send_word(8'($urandom), 1'b0, 1'b1);
      1, 2, 3, 4: begin
        send_word(8'($urandom), 1'b0, 1'b0);
        send_word(CH_APOS, 1'b0, 1'b0);
      end
      5, 6: begin
        send_word(8'($urandom), 1'b0, 1'b0);
        send_word(8'($urandom), 1'b0, 1'b0);
      end
      7: begin
        send_word(8'($urandom), 1'b0, 1'b0);
        send_word(8'($urandom), 1'b0, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 6))
      send_word(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
  endtask

  // ---------------------------------------------------------------------
  // Directed rows. Result given only where it is obvious; the rest come
  // from the predictor.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic [7:0]  c;
    logic        f;
    logic        e;
    logic        typed;
    lex_result_t res;
  } dir_row_t;

  localparam lex_result_t NO_RES = '0;
  localparam int N_DIRECTED = 28;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // idle, not first: echoed, idle status (low extreme of ch)
    '{8'h00, 1'b0, 1'b0, 1'b1, '{8'h00, ST_IDLE, KIND_NONE, 12'd0}},
    // first with end of source: ch ignored
    '{8'hFF, 1'b1, 1'b1, 1'b1, '{8'h00, ST_NOLIT, KIND_NONE, 12'd0}},
    // first on a char that starts nothing
    '{8'hFF, 1'b1, 1'b0, 1'b1, '{8'hFF, ST_NOLIT, KIND_NONE, 12'd0}},
    // sized bit string 1UX"<80>"
    '{"1",   1'b1, 1'b0, 1'b1, '{"1", ST_PENDING, KIND_NONE, 12'd0}},
    '{"U",   1'b0, 1'b0, 1'b0, NO_RES},
    '{"X",   1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_DQUOTE, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_DQUOTE, 1'b0, 1'b0, 1'b0, NO_RES},
    // plain bit string broken by a newline
    '{CH_DQUOTE, 1'b1, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_NL, 1'b0, 1'b0, 1'b0, NO_RES},
    // numeric with exponent sign and hash, ended by a space
    '{"9",   1'b1, 1'b0, 1'b0, NO_RES},
    '{"E",   1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_MINUS, 1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_HASH,  1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h20, 1'b0, 1'b0, 1'b0, NO_RES},
    // numeric dropped by a new first word, then a character literal
    '{"0",   1'b1, 1'b0, 1'b0, NO_RES},
    '{CH_APOS, 1'b1, 1'b0, 1'b0, NO_RES},
    '{"a",   1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_APOS, 1'b0, 1'b0, 1'b0, NO_RES},
    // tick cut short by end of source
    '{CH_APOS, 1'b1, 1'b0, 1'b0, NO_RES},
    '{"q",   1'b0, 1'b1, 1'b1, '{8'h00, ST_DONE, KIND_TICK, 12'd1}},
    // tick followed by two ordinary chars
    '{CH_APOS, 1'b1, 1'b0, 1'b0, NO_RES},
    '{"b",   1'b0, 1'b0, 1'b0, NO_RES},
    '{"c",   1'b0, 1'b0, 1'b0, NO_RES},
    // bit string open at end of source
    '{CH_DQUOTE, 1'b1, 1'b0, 1'b0, NO_RES},
    '{"x",   1'b0, 1'b1, 1'b0, NO_RES}
  };

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    bit mid_pause_done;
    mid_pause_done = 1'b0;
    lex_clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_word(DIRECTED[i].c, DIRECTED[i].f, DIRECTED[i].e, DIRECTED[i].typed,
                DIRECTED[i].res);
    wait_drained();

    // mostly well-formed literals with random content, some noise
    while (words_sent < RANDOM_WORDS) begin
      if (!mid_pause_done && words_sent >= RANDOM_WORDS / 2) begin
        wait_drained();
        mid_pause_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: gen_numeric();
        3, 4:    gen_sized_bits();
        5:       gen_plain_bits();
        6, 7:    gen_tick();
        default: gen_noise();
      endcase
    end

    wait_drained();
    repeat (8) @(posedge clk);  // catch any stray result words
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls, quiet runs, and one long hold-off that
  // fills both internal registers and backs up the input.
  // ---------------------------------------------------------------------
  int  stall_left = 0;
  int  run_left = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (!long_hold_done && words_sent >= HOLD_AT) begin
        long_hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (run_left > 0) begin
          run_left--;
        end else begin
          stall_left = gap_cycles();
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(0, 6);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: every accepted word against the oldest prediction
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (predicted_words.size() == 0) begin
        $error("result word with nothing outstanding");
        mismatches++;
      end else begin
        want = predicted_words.pop_front();
        check_field("out_char", 16'(want.out_char), 16'(out_char));
        check_field("status", 16'(want.status), 16'(status));
        check_field("token_kind", 16'(want.token_kind), 16'(token_kind));
        check_field("token_length", 16'(want.token_length), 16'(token_length));
      end
    end
  end

endmodule

### hdl_literal_lexer_core.f
rtl/hll_pkg.sv
rtl/hll_step.sv
rtl/hdl_literal_lexer_core.sv
tb/tb_top.sv
